FILE: rtl/cfxa_pkg.sv
package cfxa_pkg;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_INC = 3'd4,
      MODE_DEC = 3'd5,
      MODE_MOD = 3'd6,
      MODE_CMP = 3'd7
   } mode_type;

endpackage

FILE: rtl/cfxa_if.sv
interface cfxa_req_if import cfxa_pkg::*; #(parameter int WORD_BITS = 32);
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [WORD_BITS-1:0] a_real;
   logic [WORD_BITS-1:0] a_imag;
   logic [WORD_BITS-1:0] b_real;
   logic [WORD_BITS-1:0] b_imag;

   modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cfxa_rsp_if import cfxa_pkg::*; #(parameter int WORD_BITS = 32);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] out_real;
   logic [WORD_BITS-1:0] out_imag;
   logic                 is_greater;
   logic                 is_less;
   logic                 is_equal;
   logic                 divide_by_zero;
   logic                 saturated;

   modport source (output valid, out_real, out_imag, is_greater, is_less, is_equal,
                   divide_by_zero, saturated, input ready);
   modport sink (input valid, out_real, out_imag, is_greater, is_less, is_equal,
                 divide_by_zero, saturated, output ready);
endinterface

FILE: rtl/complex_fixed_point_alu_core.sv
// channel   dir   handshake          payload
// req_bus   in    valid / ready      mode, a_real, a_imag, b_real, b_imag
// rsp_bus   out   valid / ready      out_real, out_imag, is_greater, is_less,
//                                    is_equal, divide_by_zero, saturated
//
// one item per cycle unless a result is held on rsp_bus
// registers a_ff, b_ff, c_ff, d_ff, stp_ff, out_ff; one quotient/root bit per stage
// reset clears only the stage valid bits, synchronously
// a result held on rsp_bus freezes the whole pipeline, req_bus.ready drops with it
module complex_fixed_point_alu_core import cfxa_pkg::*; #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   cfxa_req_if.sink    req_bus,
   cfxa_rsp_if.source  rsp_bus
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int RW = 2 * W + F;
   localparam int DW = 3 * W;
   localparam int NV = W + 6;

   localparam logic signed [SW-1:0] WMAX   = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
   localparam logic signed [SW-1:0] WMIN   = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};
   localparam logic signed [SW-1:0] ONE_FX = SW'(1) << F;

   typedef struct packed {
      logic [W-1:0] re;
      logic [W-1:0] im;
      logic         gt;
      logic         lt;
      logic         eq;
      logic         dz;
      logic         sat;
   } res_type;

   typedef struct packed {
      mode_type     mode;
      logic [W-1:0] ar;
      logic [W-1:0] ai;
      logic [W-1:0] br;
      logic [W-1:0] bi;
   } opnd_type;

   typedef struct packed {
      mode_type          mode;
      logic [7:0][PW-1:0] prod;
      res_type           res;
   } prod_type;

   typedef struct packed {
      mode_type      mode;
      logic [SW-1:0] mul_re;
      logic [SW-1:0] mul_im;
      logic [SW-1:0] num_re;
      logic [SW-1:0] num_im;
      logic [PW-1:0] den;
      logic [PW-1:0] sa;
      res_type       res;
   } sum_type;

   typedef struct packed {
      mode_type      mode;
      logic [RW-1:0] rem_re;
      logic [RW-1:0] rem_im;
      logic [W-1:0]  q_re;
      logic [W-1:0]  q_im;
      logic          neg_re;
      logic          neg_im;
      logic          ovf_re;
      logic          ovf_im;
      logic [PW-1:0] den;
      logic [PW-1:0] sq_rem;
      logic [W-1:0]  root;
      res_type       res;
   } step_type;

   function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] x);
      logic [W:0] r;
      if (x > WMAX) begin
         r = {1'b1, WMAX[W-1:0]};
      end else if (x < WMIN) begin
         r = {1'b1, WMIN[W-1:0]};
      end else begin
         r = {1'b0, x[W-1:0]};
      end
      return r;
   endfunction

   function automatic logic [PW-1:0] smul(input logic [W-1:0] x, input logic [W-1:0] y);
      logic signed [W-1:0]  xs;
      logic signed [W-1:0]  ys;
      logic signed [PW-1:0] p;
      xs = $signed(x);
      ys = $signed(y);
      p  = xs * ys;
      return p;
   endfunction

   logic [NV-1:0] vld_ff, vld_in;
   logic          adv;
   opnd_type      a_ff, a_in;
   prod_type      b_ff, b_in;
   sum_type       c_ff, c_in;
   step_type      d_ff, d_in;
   step_type      stp_ff [W+1];
   step_type      stp_in [W+1];
   res_type       out_ff, out_in;

   assign adv           = !vld_ff[NV-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign vld_in        = {vld_ff[NV-2:0], req_bus.valid};

   // input register
   always_comb begin
      a_in.mode = req_bus.mode;
      a_in.ar   = req_bus.a_real;
      a_in.ai   = req_bus.a_imag;
      a_in.br   = req_bus.b_real;
      a_in.bi   = req_bus.b_imag;
   end

   // products, plus add / sub / inc / dec finished here
   always_comb begin
      logic signed [SW-1:0] xa_re, xa_im, op_re, op_im, s_re, s_im;
      logic [W:0]           r_re, r_im;
      logic                 use_b, do_sub;
      b_in.mode    = a_ff.mode;
      b_in.prod[0] = smul(a_ff.ar, a_ff.br);
      b_in.prod[1] = smul(a_ff.ai, a_ff.bi);
      b_in.prod[2] = smul(a_ff.ai, a_ff.br);
      b_in.prod[3] = smul(a_ff.ar, a_ff.bi);
      b_in.prod[4] = smul(a_ff.ar, a_ff.ar);
      b_in.prod[5] = smul(a_ff.ai, a_ff.ai);
      b_in.prod[6] = smul(a_ff.br, a_ff.br);
      b_in.prod[7] = smul(a_ff.bi, a_ff.bi);
      use_b  = (a_ff.mode == MODE_ADD) || (a_ff.mode == MODE_SUB);
      do_sub = (a_ff.mode == MODE_SUB) || (a_ff.mode == MODE_DEC);
      xa_re  = SW'($signed(a_ff.ar));
      xa_im  = SW'($signed(a_ff.ai));
      op_re  = use_b ? SW'($signed(a_ff.br)) : ONE_FX;
      op_im  = use_b ? SW'($signed(a_ff.bi)) : ONE_FX;
      s_re   = do_sub ? xa_re - op_re : xa_re + op_re;
      s_im   = do_sub ? xa_im - op_im : xa_im + op_im;
      r_re   = sat_wide(s_re);
      r_im   = sat_wide(s_im);
      b_in.res = '0;
      if (use_b || (a_ff.mode == MODE_INC) || (a_ff.mode == MODE_DEC)) begin
         b_in.res.re  = r_re[W-1:0];
         b_in.res.im  = r_im[W-1:0];
         b_in.res.sat = r_re[W] | r_im[W];
      end
   end

   // product sums
   always_comb begin
      logic signed [SW-1:0] p0, p1, p2, p3;
      p0 = SW'($signed(b_ff.prod[0]));
      p1 = SW'($signed(b_ff.prod[1]));
      p2 = SW'($signed(b_ff.prod[2]));
      p3 = SW'($signed(b_ff.prod[3]));
      c_in.mode   = b_ff.mode;
      c_in.mul_re = p0 - p1;
      c_in.mul_im = p2 + p3;
      c_in.num_re = p0 + p1;
      c_in.num_im = p2 - p3;
      c_in.den    = b_ff.prod[6] + b_ff.prod[7];
      c_in.sa     = b_ff.prod[4] + b_ff.prod[5];
      c_in.res    = b_ff.res;
   end

   // multiply rounding, compare, divide-by-zero flag, divider operand magnitudes
   always_comb begin
      logic signed [SW-1:0] m_re, m_im, n_re, n_im;
      logic [W:0]           r_re, r_im;
      logic [SW-1:0]        g_re, g_im;
      m_re = $signed(c_ff.mul_re) >>> F;
      m_im = $signed(c_ff.mul_im) >>> F;
      r_re = sat_wide(m_re);
      r_im = sat_wide(m_im);
      n_re = $signed(c_ff.num_re);
      n_im = $signed(c_ff.num_im);
      g_re = (n_re < 0) ? SW'(-n_re) : SW'(n_re);
      g_im = (n_im < 0) ? SW'(-n_im) : SW'(n_im);
      d_in.mode   = c_ff.mode;
      d_in.rem_re = RW'(g_re[PW-1:0]);
      d_in.rem_im = RW'(g_im[PW-1:0]);
      d_in.q_re   = '0;
      d_in.q_im   = '0;
      d_in.neg_re = n_re < 0;
      d_in.neg_im = n_im < 0;
      d_in.ovf_re = 1'b0;
      d_in.ovf_im = 1'b0;
      d_in.den    = c_ff.den;
      d_in.sq_rem = c_ff.sa;
      d_in.root   = '0;
      d_in.res    = c_ff.res;
      unique case (c_ff.mode)
         MODE_MUL: begin
            d_in.res.re  = r_re[W-1:0];
            d_in.res.im  = r_im[W-1:0];
            d_in.res.sat = r_re[W] | r_im[W];
         end
         MODE_CMP: begin
            d_in.res.gt = c_ff.sa > c_ff.den;
            d_in.res.lt = c_ff.sa < c_ff.den;
            d_in.res.eq = c_ff.sa == c_ff.den;
         end
         MODE_DIV: begin
            d_in.res.dz = c_ff.den == '0;
         end
         default: begin
         end
      endcase
   end

   // scale dividends, flag quotients of 2^W or more
   always_comb begin
      logic [RW-1:0] sh_re, sh_im;
      sh_re = d_ff.rem_re << F;
      sh_im = d_ff.rem_im << F;
      stp_in[0]        = d_ff;
      stp_in[0].rem_re = sh_re;
      stp_in[0].rem_im = sh_im;
      stp_in[0].ovf_re = DW'(sh_re) >= (DW'(d_ff.den) << W);
      stp_in[0].ovf_im = DW'(sh_im) >= (DW'(d_ff.den) << W);
   end

   // one bit of each quotient and one root bit per stage
   for (genvar g = 1; g <= W; g++) begin : g_step
      localparam int K = W - g;
      always_comb begin
         logic [DW-1:0] den_sh;
         logic [SW-1:0] trial;
         stp_in[g] = stp_ff[g-1];
         den_sh    = DW'(stp_ff[g-1].den) << K;
         trial     = (SW'(stp_ff[g-1].root) << (K + 1)) | (SW'(1) << (2 * K));
         if (DW'(stp_ff[g-1].rem_re) >= den_sh) begin
            stp_in[g].rem_re  = stp_ff[g-1].rem_re - RW'(den_sh);
            stp_in[g].q_re[K] = 1'b1;
         end
         if (DW'(stp_ff[g-1].rem_im) >= den_sh) begin
            stp_in[g].rem_im  = stp_ff[g-1].rem_im - RW'(den_sh);
            stp_in[g].q_im[K] = 1'b1;
         end
         if (SW'(stp_ff[g-1].sq_rem) >= trial) begin
            stp_in[g].sq_rem  = stp_ff[g-1].sq_rem - PW'(trial);
            stp_in[g].root[K] = 1'b1;
         end
      end
   end

   // sign and clamp of quotients and root
   always_comb begin
      logic signed [SW-1:0] x_re, x_im, x_rt;
      logic [W:0]           r_re, r_im, r_rt;
      step_type             s;
      s    = stp_ff[W];
      x_re = s.neg_re ? -SW'(s.q_re) : SW'(s.q_re);
      x_im = s.neg_im ? -SW'(s.q_im) : SW'(s.q_im);
      x_rt = SW'(s.root);
      r_re = s.ovf_re ? {1'b1, (s.neg_re ? WMIN[W-1:0] : WMAX[W-1:0])} : sat_wide(x_re);
      r_im = s.ovf_im ? {1'b1, (s.neg_im ? WMIN[W-1:0] : WMAX[W-1:0])} : sat_wide(x_im);
      r_rt = sat_wide(x_rt);
      out_in = s.res;
      unique case (s.mode)
         MODE_DIV: begin
            if (!s.res.dz) begin
               out_in.re  = r_re[W-1:0];
               out_in.im  = r_im[W-1:0];
               out_in.sat = r_re[W] | r_im[W];
            end
         end
         MODE_MOD: begin
            out_in.re  = r_rt[W-1:0];
            out_in.im  = '0;
            out_in.sat = r_rt[W];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         d_ff   <= d_in;
         out_ff <= out_in;
         for (int i = 0; i <= W; i++) begin
            stp_ff[i] <= stp_in[i];
         end
      end
   end

   assign rsp_bus.valid          = vld_ff[NV-1];
   assign rsp_bus.out_real       = out_ff.re;
   assign rsp_bus.out_imag       = out_ff.im;
   assign rsp_bus.is_greater     = out_ff.gt;
   assign rsp_bus.is_less        = out_ff.lt;
   assign rsp_bus.is_equal       = out_ff.eq;
   assign rsp_bus.divide_by_zero = out_ff.dz;
   assign rsp_bus.saturated      = out_ff.sat;

   a_cmp_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> $onehot0({out_ff.gt, out_ff.lt, out_ff.eq}))
      else $error("more than one compare flag set");

   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && out_ff.dz |-> out_ff.re == '0 && out_ff.im == '0 && !out_ff.sat)
      else $error("divide by zero result not cleared");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

endmodule

FILE: tb/sv/complex_fixed_point_alu_core_tb.sv
`timescale 1ns / 100ps

module complex_fixed_point_alu_core_tb;
   import cfxa_pkg::*;

   localparam int WORD_BITS     = 32;
   localparam int FRACTION_BITS = 16;
   localparam int LATENCY       = WORD_BITS + 6;

   typedef struct packed {
      logic signed [31:0] out_real;
      logic signed [31:0] out_imag;
      logic               is_greater;
      logic               is_less;
      logic               is_equal;
      logic               divide_by_zero;
      logic               saturated;
   } alu_result_type;

   // exact complex arithmetic on 128-bit signed integers
   function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                     inout logic sat);
      logic signed [127:0] top;
      logic signed [127:0] bot;
      top = 128'sd2147483647;
      bot = -128'sd2147483648;
      if (v > top) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (v < bot) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (n < 0) ? -n : n;
      q = mag / d;
      return (n < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         logic [63:0] t;
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic alu_result_type compute_alu(input mode_type mode,
         input logic signed [31:0] ar, input logic signed [31:0] ai,
         input logic signed [31:0] br, input logic signed [31:0] bi);
      alu_result_type r;
      logic signed [127:0] xr, xi, yr, yi, one, den, sa, sb, nr, ni;
      logic sat;
      r = '0;
      sat = 0;
      xr = ar; xi = ai; yr = br; yi = bi;
      one = 128'sd1 <<< FRACTION_BITS;
      case (mode)
         MODE_ADD: begin
            r.out_real = clamp_word(xr + yr, sat);
            r.out_imag = clamp_word(xi + yi, sat);
         end
         MODE_SUB: begin
            r.out_real = clamp_word(xr - yr, sat);
            r.out_imag = clamp_word(xi - yi, sat);
         end
         MODE_MUL: begin
            // arithmetic shift floors toward minus infinity
            r.out_real = clamp_word((xr * yr - xi * yi) >>> FRACTION_BITS, sat);
            r.out_imag = clamp_word((xi * yr + xr * yi) >>> FRACTION_BITS, sat);
         end
         MODE_DIV: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               nr = (xr * yr + xi * yi) <<< FRACTION_BITS;
               ni = (xi * yr - xr * yi) <<< FRACTION_BITS;
               r.out_real = clamp_word(trunc_div(nr, den), sat);
               r.out_imag = clamp_word(trunc_div(ni, den), sat);
            end
         end
         MODE_INC: begin
            r.out_real = clamp_word(xr + one, sat);
            r.out_imag = clamp_word(xi + one, sat);
         end
         MODE_DEC: begin
            r.out_real = clamp_word(xr - one, sat);
            r.out_imag = clamp_word(xi - one, sat);
         end
         MODE_MOD: begin
            sa = xr * xr + xi * xi;
            r.out_real = clamp_word($signed({64'd0, int_sqrt(sa[63:0])}), sat);
         end
         default: begin
            sa = xr * xr + xi * xi;
            sb = yr * yr + yi * yi;
            r.is_greater = sa > sb;
            r.is_less    = sa < sb;
            r.is_equal   = sa == sb;
         end
      endcase
      r.saturated = sat;
      return r;
   endfunction

   class alu_scoreboard;
      alu_result_type pending[$];
      int             mismatches;

      function void note_request(mode_type m, logic [31:0] ar, logic [31:0] ai,
                                 logic [31:0] br, logic [31:0] bi);
         pending.push_back(compute_alu(m, ar, ai, br, bi));
      endfunction

      function void check_result(alu_result_type got);
         alu_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected re %h im %h flags %b, got re %h im %h flags %b",
                        want.out_real, want.out_imag, want[4:0],
                        got.out_real, got.out_imag, got[4:0]);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #6 clock = ~clock;

   cfxa_req_if #(.WORD_BITS(WORD_BITS)) req_bus ();
   cfxa_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_bus ();

   complex_fixed_point_alu_core #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS))
      i_dut (.clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source));

   alu_scoreboard results = new();
   bit idle_enable = 1;
   int hold_off_cycles = 0;

   // rising edge: note transfers on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            results.note_request(req_bus.mode, req_bus.a_real, req_bus.a_imag,
                                 req_bus.b_real, req_bus.b_imag);
         if (rsp_bus.valid && rsp_bus.ready)
            results.check_result({rsp_bus.out_real, rsp_bus.out_imag, rsp_bus.is_greater,
                                  rsp_bus.is_less, rsp_bus.is_equal,
                                  rsp_bus.divide_by_zero, rsp_bus.saturated});
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin
      int burst;
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_bus.ready <= 0;
            repeat (burst) @(negedge clock);
         end
         rsp_bus.ready <= 1;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
         5: return $signed($urandom_range(0, 32'hffff)) - 32'sh8000;
         default: return $urandom();
      endcase
   endfunction

   // send one item, waiting for the transfer, then sometimes drop valid for a while
   task automatic send_item(mode_type m, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
      req_bus.valid  <= 1;
      req_bus.mode   <= m;
      req_bus.a_real <= ar;
      req_bus.a_imag <= ai;
      req_bus.b_real <= br;
      req_bus.b_imag <= bi;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 0;
      while (results.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      mode_type m;
      logic [31:0] ar, ai, br, bi;
      req_bus.valid  = 0;
      req_bus.mode   = MODE_ADD;
      req_bus.a_real = 0;
      req_bus.a_imag = 0;
      req_bus.b_real = 0;
      req_bus.b_imag = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: every mode at the extremes and the special cases
      for (int k = 0; k < 8; k++) begin
         m = mode_type'(k);
         send_item(m, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
         send_item(m, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      end
      send_item(MODE_DIV, 32'h00030000, 32'hfffe0000, 32'h0, 32'h0);
      send_item(MODE_DIV, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h1);
      send_item(MODE_DIV, 32'hffffffff, 32'h1, 32'h00030000, 32'h0);
      send_item(MODE_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0);
      send_item(MODE_MOD, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
      send_item(MODE_CMP, 32'h00030000, 32'h00040000, 32'h00050000, 32'h0);
      send_item(MODE_CMP, 32'h1, 32'h0, 32'h0, 32'h0);
      send_item(MODE_CMP, 32'h0, 32'h0, 32'h0, 32'hffffffff);
      send_item(MODE_INC, 32'h7fff0000, 32'h0, 32'h0, 32'h0);

      // sender pauses until every result is back
      drain_results();

      // long receiver hold-off while the sender keeps offering items
      hold_off_cycles = 3 * LATENCY;
      for (int n = 0; n < 1300; n++) begin
         if (n == 1100) idle_enable = 0;
         m = mode_type'($urandom_range(0, 7));
         ar = pick_word();
         ai = pick_word();
         br = pick_word();
         bi = pick_word();
         if (n % 97 == 40) hold_off_cycles = $urandom_range(2 * LATENCY, 4 * LATENCY);
         send_item(m, ar, ai, br, bi);
      end

      drain_results();
      repeat (LATENCY + 10) @(negedge clock);
      if (results.mismatches == 0 && results.pending.size() == 0)
         $display("complex_fixed_point_alu_core: match");
      else
         $display("complex_fixed_point_alu_core: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("complex_fixed_point_alu_core: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/cfxa_pkg.sv
rtl/cfxa_if.sv
rtl/complex_fixed_point_alu_core.sv
tb/sv/complex_fixed_point_alu_core_tb.sv
